// ===== rtl/gdir_pkg.sv =====
// Shared types and constants for the GTP-U decapsulating forwarder.
// Used by every module under rtl; depends on nothing.
package gdir_pkg;

	localparam int ETH_BYTES           = 14;
	localparam int UDP_BYTES           = 8;
	localparam int TUNNEL_HEADER_BYTES = 8;
	localparam int MIN_IP_HDR_BYTES    = 20;
	localparam int MAX_IP_HDR_BYTES    = 60;
	localparam int MAX_INNER_LEN       = 1500;
	localparam int HELD_MAX            = 4;

	localparam int POS_W   = 14;
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int OHB_W   = 6;
	localparam int START_W = $clog2(ETH_BYTES + MAX_IP_HDR_BYTES + UDP_BYTES
		+ TUNNEL_HEADER_BYTES + 1);
	localparam int IDX_W   = 5;
	localparam int IDX_SAT = 20;
	localparam int SUM_W   = 20;
	localparam int LEN_W   = 16;
	localparam int HELD_W  = 3;
	localparam int KCNT_W  = 5;

	localparam logic [3:0]  IHL_MASK       = 4'h0f;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OLD_SOURCE_IP  = 3'd0,
		REG_NEW_SOURCE_IP  = 3'd1,
		REG_NEW_DEST_IP    = 3'd2,
		REG_NEW_SOURCE_MAC = 3'd3,
		REG_NEW_DEST_MAC   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PARSE,
		MODE_FORWARD,
		MODE_DONE
	} frame_mode_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_START,
		CMD_BYTE
	} cmd_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} tx_item_t;

	// Command from the parser to the emitter.
	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        data;
		logic [IDX_W-1:0]  idx;
		logic [HELD_W-1:0] held;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [31:0] old_source_ip;
		logic [31:0] new_source_ip;
		logic [31:0] new_dest_ip;
		logic [47:0] new_source_mac;
		logic [47:0] new_dest_mac;
	} cfg_t;

endpackage

// ===== rtl/gdir_front.sv =====
// Frame parser: tracks outer headers, checks the outer source and turns
// inner bytes into commands for the emitter. Depends on gdir_pkg.
module gdir_front import gdir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  rx_item_t    rx_item,
	input  logic [31:0] old_source_ip,
	output logic        cmd_push,
	output cmd_t        cmd
);

	logic [POS_W-1:0] byte_position_q, byte_position_d;
	logic [OHB_W-1:0] outer_header_bytes_q, outer_header_bytes_d;
	logic             source_matches_q, source_matches_d;
	logic [LEN_W-1:0] inner_total_length_q, inner_total_length_d;
	logic [LEN_W-1:0] emitted_count_q, emitted_count_d;
	frame_mode_t      frame_mode_q, frame_mode_d;

	logic [START_W-1:0] start;
	logic [POS_W-1:0]   off;
	logic               in_zone;
	logic [LEN_W-1:0]   total_len;
	logic [LEN_W-1:0]   emitted_inc;
	logic [HELD_W-1:0]  held;
	logic               ends;
	logic [1:0]         ip_sel;
	logic [5:0]         ihl_bytes;

	assign start = START_W'(ETH_BYTES + UDP_BYTES + TUNNEL_HEADER_BYTES)
		+ START_W'(outer_header_bytes_q);
	assign off = byte_position_q - POS_W'(start);
	assign in_zone = (byte_position_q > POS_W'(ETH_BYTES))
		&& (byte_position_q >= POS_W'(start));
	assign total_len = {inner_total_length_q[15:8], rx_item.in_byte};
	assign emitted_inc = emitted_count_q + LEN_W'(1);
	assign ip_sel = 2'(5'd29 - byte_position_q[4:0]);
	assign ihl_bytes = {rx_item.in_byte[3:0] & IHL_MASK, 2'b00};
	assign held = (total_len < LEN_W'(HELD_MAX)) ? HELD_W'(total_len) : HELD_W'(HELD_MAX);

	always_comb begin
		byte_position_d      = byte_position_q;
		outer_header_bytes_d = outer_header_bytes_q;
		source_matches_d     = source_matches_q;
		inner_total_length_d = inner_total_length_q;
		emitted_count_d      = emitted_count_q;
		frame_mode_d         = frame_mode_q;
		cmd_push             = 1'b0;
		cmd.kind             = CMD_HOLD;
		cmd.data             = rx_item.in_byte;
		cmd.idx              = IDX_W'(off[1:0]);
		cmd.held             = held;
		cmd.last             = 1'b0;
		ends                 = 1'b0;

		if (accept) begin
			unique case (frame_mode_q)
				MODE_PARSE: begin
					if (byte_position_q == POS_W'(ETH_BYTES))
						outer_header_bytes_d = (ihl_bytes < 6'(MIN_IP_HDR_BYTES))
							? OHB_W'(MIN_IP_HDR_BYTES) : ihl_bytes;
					if (byte_position_q >= POS_W'(26) && byte_position_q <= POS_W'(29)
						&& rx_item.in_byte != old_source_ip[{ip_sel, 3'b000} +: 8])
						source_matches_d = 1'b0;
					if (in_zone) begin
						cmd_push = 1'b1;
						if (off[1:0] == 2'd2)
							inner_total_length_d = {rx_item.in_byte, 8'h00};
						if (off[1:0] == 2'd3) begin
							inner_total_length_d = total_len;
							if (!source_matches_q || total_len > LEN_W'(MAX_INNER_LEN)) begin
								frame_mode_d = MODE_DONE;
							end else begin
								ends = (total_len <= LEN_W'(HELD_MAX)) || rx_item.in_last;
								cmd.kind = CMD_START;
								cmd.last = ends;
								emitted_count_d = LEN_W'(held);
								frame_mode_d = ends ? MODE_DONE : MODE_FORWARD;
							end
						end
					end
				end
				MODE_FORWARD: begin
					ends = (emitted_inc >= inner_total_length_q) || rx_item.in_last;
					cmd_push = 1'b1;
					cmd.kind = CMD_BYTE;
					cmd.idx = (off >= POS_W'(IDX_SAT)) ? IDX_W'(IDX_SAT) : off[IDX_W-1:0];
					cmd.last = ends;
					emitted_count_d = emitted_inc;
					if (ends)
						frame_mode_d = MODE_DONE;
				end
				MODE_DONE: begin
				end
				default: begin
				end
			endcase

			if (byte_position_q < POS_W'(POS_MAX))
				byte_position_d = byte_position_q + POS_W'(1);

			// in_last always starts a new frame
			if (rx_item.in_last) begin
				byte_position_d      = '0;
				outer_header_bytes_d = '0;
				source_matches_d     = 1'b1;
				inner_total_length_d = '0;
				emitted_count_d      = '0;
				frame_mode_d         = MODE_PARSE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q      <= '0;
			outer_header_bytes_q <= '0;
			source_matches_q     <= 1'b1;
			inner_total_length_q <= '0;
			emitted_count_q      <= '0;
			frame_mode_q         <= MODE_PARSE;
		end else begin
			byte_position_q      <= byte_position_d;
			outer_header_bytes_q <= outer_header_bytes_d;
			source_matches_q     <= source_matches_d;
			inner_total_length_q <= inner_total_length_d;
			emitted_count_q      <= emitted_count_d;
			frame_mode_q         <= frame_mode_d;
		end
	end

endmodule

// ===== rtl/gdir_cmd_fifo.sv =====
// Command queue between parser and emitter, FIFO_DEPTH entries.
// Depends on gdir_pkg for the command type and depth.
module gdir_cmd_fifo import gdir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output cmd_t rdata,
	output logic empty
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (rd)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (wr && !rd)
				count_q <= count_q + (FIFO_AW+1)'(1);
			else if (rd && !wr)
				count_q <= count_q - (FIFO_AW+1)'(1);
		end
	end

endmodule

// ===== rtl/gdir_back.sv =====
// Frame emitter: builds the Ethernet header, replays held inner bytes,
// rewrites addresses and checksum, and drives the output register.
// Depends on gdir_pkg.
module gdir_back import gdir_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     head,
	input  logic     head_empty,
	output logic     head_pop,
	input  cfg_t     cfg,
	output tx_item_t tx_item,
	output logic     empty,
	input  logic     pop
);

	logic [7:0]        hold_q [HELD_MAX];
	logic [SUM_W-1:0]  checksum_sum_q, checksum_sum_d;
	logic              bursting_q, bursting_d;
	logic [KCNT_W-1:0] k_q, k_d;
	logic [KCNT_W-1:0] total_q, total_d;
	logic              ends_q, ends_d;
	tx_item_t          out_q;
	logic              out_valid_q;

	logic             adv;
	logic             emit;
	tx_item_t         emit_item;
	logic [SUM_W-1:0] cs_s;
	logic [16:0]      cs_f;
	logic [15:0]      cs_g;
	logic [15:0]      csum;
	logic [2:0]       mac_sel;
	logic [1:0]       hold_sel;
	logic [1:0]       ip_sel;
	logic             hold_wr;
	logic [1:0]       hold_wr_idx;

	function automatic logic [SUM_W-1:0] sum_term(input logic odd, input logic [7:0] b);
		sum_term = odd ? SUM_W'(b) : SUM_W'({b, 8'h00});
	endfunction

	assign tx_item = out_q;
	assign empty   = !out_valid_q;
	assign adv     = !out_valid_q || pop;

	// ones-complement checksum over bytes 0..9 plus the new addresses
	assign cs_s = checksum_sum_q
		+ SUM_W'(cfg.new_source_ip[31:16]) + SUM_W'(cfg.new_source_ip[15:0])
		+ SUM_W'(cfg.new_dest_ip[31:16]) + SUM_W'(cfg.new_dest_ip[15:0]);
	assign cs_f = 17'(cs_s[SUM_W-1:16]) + 17'(cs_s[15:0]);
	assign cs_g = cs_f[15:0] + 16'(cs_f[16]);
	assign csum = ~cs_g;

	assign mac_sel  = 3'(5'd5 - (k_q >= KCNT_W'(6) ? k_q - KCNT_W'(6) : k_q));
	assign hold_sel = 2'(k_q - KCNT_W'(ETH_BYTES));
	assign ip_sel   = 2'(~head.idx[1:0]);

	always_comb begin
		checksum_sum_d      = checksum_sum_q;
		bursting_d          = bursting_q;
		k_d                 = k_q;
		total_d             = total_q;
		ends_d              = ends_q;
		head_pop            = 1'b0;
		emit                = 1'b0;
		emit_item.out_byte  = head.data;
		emit_item.out_last  = head.last;
		hold_wr             = 1'b0;
		hold_wr_idx         = head.idx[1:0];

		if (bursting_q) begin
			if (adv) begin
				emit = 1'b1;
				emit_item.out_last = (k_q + KCNT_W'(1) == total_q) && ends_q;
				if (k_q < KCNT_W'(6))
					emit_item.out_byte = cfg.new_dest_mac[{mac_sel, 3'b000} +: 8];
				else if (k_q < KCNT_W'(12))
					emit_item.out_byte = cfg.new_source_mac[{mac_sel, 3'b000} +: 8];
				else if (k_q == KCNT_W'(12))
					emit_item.out_byte = ETHERTYPE_IPV4[15:8];
				else if (k_q == KCNT_W'(13))
					emit_item.out_byte = ETHERTYPE_IPV4[7:0];
				else begin
					emit_item.out_byte = hold_q[hold_sel];
					checksum_sum_d = checksum_sum_q + sum_term(hold_sel[0], hold_q[hold_sel]);
				end
				k_d = k_q + KCNT_W'(1);
				if (k_q + KCNT_W'(1) == total_q)
					bursting_d = 1'b0;
			end
		end else if (!head_empty) begin
			unique case (head.kind)
				CMD_HOLD: begin
					head_pop = 1'b1;
					hold_wr  = 1'b1;
				end
				CMD_START: begin
					if (adv) begin
						head_pop    = 1'b1;
						hold_wr     = 1'b1;
						hold_wr_idx = 2'd3;
						// first destination MAC byte goes out with the start
						emit = 1'b1;
						emit_item.out_byte = cfg.new_dest_mac[47:40];
						emit_item.out_last = 1'b0;
						checksum_sum_d = '0;
						bursting_d = 1'b1;
						k_d = KCNT_W'(1);
						total_d = KCNT_W'(ETH_BYTES) + KCNT_W'(head.held);
						ends_d = head.last;
					end
				end
				CMD_BYTE: begin
					if (adv) begin
						head_pop = 1'b1;
						emit = 1'b1;
						if (head.idx <= IDX_W'(9))
							checksum_sum_d = checksum_sum_q + sum_term(head.idx[0], head.data);
						if (head.idx == IDX_W'(10))
							emit_item.out_byte = csum[15:8];
						else if (head.idx == IDX_W'(11))
							emit_item.out_byte = csum[7:0];
						else if (head.idx >= IDX_W'(12) && head.idx <= IDX_W'(15))
							emit_item.out_byte = cfg.new_source_ip[{ip_sel, 3'b000} +: 8];
						else if (head.idx >= IDX_W'(16) && head.idx <= IDX_W'(19))
							emit_item.out_byte = cfg.new_dest_ip[{ip_sel, 3'b000} +: 8];
					end
				end
				default: begin
					head_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hold_wr)
			hold_q[hold_wr_idx] <= head.data;
		if (emit)
			out_q <= emit_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_sum_q <= '0;
			bursting_q     <= 1'b0;
			k_q            <= '0;
			total_q        <= '0;
			ends_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			checksum_sum_q <= checksum_sum_d;
			bursting_q     <= bursting_d;
			k_q            <= k_d;
			total_q        <= total_d;
			ends_q         <= ends_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/gtpu_decap_ip_rewrite.sv =====
// Top level of the GTP-U decapsulating forwarder: configuration registers,
// parser, command queue and emitter. Depends on gdir_pkg and the gdir_* modules.
//
//   channel   handshake             payload
//   ------    --------------------  ---------------------------
//   rx        push / full           rx_item (in_byte, in_last)
//   tx        empty / pop           tx_item (out_byte, out_last)
//   cfg       cfg_write             cfg_index, cfg_data
//
// One received byte is taken per cycle while full is low; full rises only when
// the 32-entry command queue is full. The emitter sends one byte per cycle
// while its output register is empty or popped; a kept frame's start sends 14
// header and up to 4 held bytes. Reset asynchronously clears control state and
// configuration, not queue, held or output data. Either side may stall at any
// time; the output register can refill in the cycle it is popped.
module gtpu_decap_ip_rewrite import gdir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  rx_item_t             rx_item,
	output logic                 empty,
	input  logic                 pop,
	output tx_item_t             tx_item,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	logic accept;
	logic cmd_push;
	cmd_t cmd;
	cmd_t head;
	logic head_empty;
	logic head_pop;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OLD_SOURCE_IP:  cfg_q.old_source_ip  <= cfg_data[31:0];
				REG_NEW_SOURCE_IP:  cfg_q.new_source_ip  <= cfg_data[31:0];
				REG_NEW_DEST_IP:    cfg_q.new_dest_ip    <= cfg_data[31:0];
				REG_NEW_SOURCE_MAC: cfg_q.new_source_mac <= cfg_data;
				REG_NEW_DEST_MAC:   cfg_q.new_dest_mac   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gdir_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_item       (rx_item),
		.old_source_ip (cfg_q.old_source_ip),
		.cmd_push      (cmd_push),
		.cmd           (cmd)
	);

	gdir_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd),
		.full   (full),
		.rd     (head_pop),
		.rdata  (head),
		.empty  (head_empty)
	);

	gdir_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.cfg        (cfg_q),
		.tx_item    (tx_item),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
